// ----- rtl/complex_arith_unit_assert.svh -----
// Assertion macros for the complex arithmetic unit checker.
// No dependencies; included by the checker file.
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// clocked property body, disabled during reset
`define CAU_PROP(p) @(posedge clk) disable iff (!rst_n) (p)

`define CAU_ASSERT(lbl, p, msg) \
  lbl: assert property (`CAU_PROP(p)) else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int CAU_FRAC_BITS = 8;
  localparam int DIV_QW        = 17;
  localparam int DIV_RW        = 50;
  localparam int SQRT_STEPS    = 16;
  localparam int LANE_DEPTH    = 17;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MAG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_EQ   = 3'd6,
    OP_NE   = 3'd7
  } op_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } div_flags_t;

  typedef struct packed {
    op_t               op;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic              truth;
  } side_t;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    if (v > 33'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -33'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic signed [15:0] div_sat(input logic [DIV_QW-1:0] q,
                                                 input div_flags_t f);
    logic [DIV_QW-1:0] nq;
    nq = -q;
    if (f.zero) begin
      return 16'sh0000;
    end else if (f.neg) begin
      if (f.ovf || q > DIV_QW'(32768)) begin
        return 16'sh8000;
      end else begin
        return nq[15:0];
      end
    end else if (f.ovf || q > DIV_QW'(32767)) begin
      return 16'sh7FFF;
    end else begin
      return q[15:0];
    end
  endfunction

  function automatic logic signed [15:0] root_sat(input logic [15:0] r);
    if (r > 16'd32767) begin
      return 16'sh7FFF;
    end else begin
      return r;
    end
  endfunction

endpackage

// ----- rtl/cau_delay.sv -----
`timescale 1ns / 1ps
// Enabled shift line that carries side data alongside the arithmetic lanes.
// No dependencies.
module cau_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_w [0:DEPTH];

  assign tap_w[0] = din;

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    logic [W-1:0] tap_r;
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r <= tap_w[s];
      end
    end
    assign tap_w[s+1] = tap_r;
  end

  assign dout = tap_w[DEPTH];

endmodule

// ----- rtl/cau_divider.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Depends on cau_pkg.
module cau_divider
  import cau_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_RW-1:0] num_i,
  input  logic [31:0]       den_i,
  input  div_flags_t        flags_i,
  output logic [DIV_QW-1:0] quo_o,
  output div_flags_t        flags_o
);

  logic [DIV_RW-1:0] r_w [0:DIV_QW];
  logic [DIV_QW-1:0] q_w [0:DIV_QW];
  logic [31:0]       d_w [0:DIV_QW];
  div_flags_t        f_w [0:DIV_QW];

  assign r_w[0]      = num_i;
  assign q_w[0]      = '0;
  assign d_w[0]      = den_i;
  assign f_w[0].neg  = flags_i.neg;
  assign f_w[0].zero = flags_i.zero;
  // quotient would need more than DIV_QW bits
  assign f_w[0].ovf  = num_i >= (DIV_RW'(den_i) << DIV_QW);

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    localparam int B = DIV_QW - 1 - s;
    logic [DIV_RW-1:0] dsh;
    logic              ge;
    logic [DIV_RW-1:0] r_r;
    logic [DIV_QW-1:0] q_r;
    logic [31:0]       d_r;
    div_flags_t        f_r;

    assign dsh = DIV_RW'(d_w[s]) << B;
    assign ge  = r_w[s] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r <= ge ? (r_w[s] - dsh) : r_w[s];
        q_r <= {q_w[s][DIV_QW-2:0], ge};
        d_r <= d_w[s];
        f_r <= f_w[s];
      end
    end

    assign r_w[s+1] = r_r;
    assign q_w[s+1] = q_r;
    assign d_w[s+1] = d_r;
    assign f_w[s+1] = f_r;
  end

  assign quo_o   = q_w[DIV_QW];
  assign flags_o = f_w[DIV_QW];

endmodule

// ----- rtl/cau_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage plus an output register.
// Depends on cau_pkg.
module cau_sqrt
  import cau_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] radicand_i,
  output logic [15:0] root_o
);

  logic [31:0] n_w [0:SQRT_STEPS];
  logic [18:0] r_w [0:SQRT_STEPS];
  logic [15:0] q_w [0:SQRT_STEPS];
  logic [15:0] root_r;

  assign n_w[0] = radicand_i;
  assign r_w[0] = '0;
  assign q_w[0] = '0;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_stage
    localparam int P = SQRT_STEPS - 1 - s;
    logic [18:0] rt;
    logic [18:0] trial;
    logic        ge;
    logic [31:0] n_r;
    logic [18:0] r_r;
    logic [15:0] q_r;

    assign rt    = {r_w[s][16:0], n_w[s][2*P+1:2*P]};
    assign trial = {1'b0, q_w[s], 2'b01};
    assign ge    = rt >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        n_r <= n_w[s];
        r_r <= ge ? (rt - trial) : rt;
        q_r <= {q_w[s][14:0], ge};
      end
    end

    assign n_w[s+1] = n_r;
    assign r_w[s+1] = r_r;
    assign q_w[s+1] = q_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= q_w[SQRT_STEPS];
    end
  end

  assign root_o = root_r;

endmodule

// ----- rtl/complex_arith_unit.sv -----
`timescale 1ns / 1ps
// Complex-number ALU on signed fixed-point operands, top level.
// Depends on cau_pkg, cau_delay, cau_divider, cau_sqrt.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata: op code and two
//   complex operands A and B. Each word yields exactly one result word on
//   out_tvalid/out_tready/out_tdata: res_re, res_im and the truth bit.
//   Ops: add, sub, mul, div, magnitude of A, conjugate of A, equal, not equal.
//   All results saturate to 16 bits; a zero divisor gives 0+0i.
// Structure: three arithmetic stages, then 17 lane stages (divider stages at one
//   quotient bit each; square-root stages at one root bit each plus a root
//   register), then one output register.
// Throughput: one word per cycle when not stalled; every stage holds a word and a valid bit.
// Stall: when out_tready is low with a result pending, the whole pipeline
//   freezes and in_tready drops; nothing is lost or repeated.
// Reset: rst_n low clears all valid bits; no result is presented after reset
//   until a new word has gone through.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // op[2:0] a_re[18:3] a_im[34:19] b_re[50:35] b_im[66:51]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // res_re[15:0] res_im[31:16] truth[32]
);

  logic adv;

  logic signed [15:0] ar, ai, br, bi;
  side_t              s1_side_nxt;

  logic signed [31:0] p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r;
  logic signed [31:0] p_arar_r, p_aiai_r, p_brbr_r, p_bibi_r;
  side_t              s1_side_r;
  logic               s1_v_r;

  logic signed [32:0] s2_mre_r, s2_mim_r, s2_nre_r, s2_nim_r;
  logic [31:0]        s2_d_r, s2_mag_r;
  side_t              s2_side_r;
  logic               s2_v_r;

  logic signed [32:0] bias_re, bias_im, mre_sh, mim_sh;
  logic [31:0]        nre_abs, nim_abs;
  side_t              s3_side_nxt;

  logic [DIV_RW-1:0]  s3_nre_r, s3_nim_r;
  logic [31:0]        s3_d_r, s3_mag_r;
  div_flags_t         s3_fre_r, s3_fim_r;
  side_t              s3_side_r;
  logic               s3_v_r;

  logic [DIV_QW-1:0]  q_re, q_im;
  div_flags_t         f_re, f_im;
  logic [15:0]        root;
  side_t              side_d;
  logic [LANE_DEPTH-1:0] vp_r;

  logic signed [15:0] res_re_nxt, res_im_nxt;
  logic signed [15:0] out_re_r, out_im_r;
  logic               out_truth_r;
  logic               out_tvalid_r;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // stage 1: products and the simple ops
  assign ar = $signed(in_tdata[18:3]);
  assign ai = $signed(in_tdata[34:19]);
  assign br = $signed(in_tdata[50:35]);
  assign bi = $signed(in_tdata[66:51]);

  always_comb begin
    s1_side_nxt.op    = op_t'(in_tdata[2:0]);
    s1_side_nxt.re    = '0;
    s1_side_nxt.im    = '0;
    s1_side_nxt.truth = 1'b0;
    case (s1_side_nxt.op)
      OP_ADD: begin
        s1_side_nxt.re = sat16(33'(ar) + 33'(br));
        s1_side_nxt.im = sat16(33'(ai) + 33'(bi));
      end
      OP_SUB: begin
        s1_side_nxt.re = sat16(33'(ar) - 33'(br));
        s1_side_nxt.im = sat16(33'(ai) - 33'(bi));
      end
      OP_CONJ: begin
        s1_side_nxt.re = ar;
        s1_side_nxt.im = sat16(-33'(ai));
      end
      OP_EQ: s1_side_nxt.truth = (ar == br) && (ai == bi);
      OP_NE: s1_side_nxt.truth = !((ar == br) && (ai == bi));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_arbr_r  <= ar * br;
      p_aibi_r  <= ai * bi;
      p_arbi_r  <= ar * bi;
      p_aibr_r  <= ai * br;
      p_arar_r  <= ar * ar;
      p_aiai_r  <= ai * ai;
      p_brbr_r  <= br * br;
      p_bibi_r  <= bi * bi;
      s1_side_r <= s1_side_nxt;
    end
  end

  // stage 2: sums
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mre_r  <= 33'(p_arbr_r) - 33'(p_aibi_r);
      s2_mim_r  <= 33'(p_arbi_r) + 33'(p_aibr_r);
      s2_nre_r  <= 33'(p_arbr_r) + 33'(p_aibi_r);
      s2_nim_r  <= 33'(p_aibr_r) - 33'(p_arbi_r);
      s2_d_r    <= $unsigned(p_brbr_r) + $unsigned(p_bibi_r);
      s2_mag_r  <= $unsigned(p_arar_r) + $unsigned(p_aiai_r);
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: product rescale, divider operand prep
  assign bias_re = s2_mre_r[32] ? ((33'sd1 <<< FRAC_BITS) - 33'sd1) : 33'sd0;
  assign bias_im = s2_mim_r[32] ? ((33'sd1 <<< FRAC_BITS) - 33'sd1) : 33'sd0;
  assign mre_sh  = (s2_mre_r + bias_re) >>> FRAC_BITS;
  assign mim_sh  = (s2_mim_r + bias_im) >>> FRAC_BITS;

  assign nre_abs = s2_nre_r[32] ? 32'(-s2_nre_r) : s2_nre_r[31:0];
  assign nim_abs = s2_nim_r[32] ? 32'(-s2_nim_r) : s2_nim_r[31:0];

  always_comb begin
    s3_side_nxt = s2_side_r;
    if (s2_side_r.op == OP_MUL) begin
      s3_side_nxt.re = sat16(mre_sh);
      s3_side_nxt.im = sat16(mim_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nre_r      <= DIV_RW'(nre_abs) << FRAC_BITS;
      s3_nim_r      <= DIV_RW'(nim_abs) << FRAC_BITS;
      s3_d_r        <= s2_d_r;
      s3_mag_r      <= s2_mag_r;
      s3_fre_r.neg  <= s2_nre_r[32];
      s3_fre_r.zero <= s2_d_r == 32'd0;
      s3_fre_r.ovf  <= 1'b0;
      s3_fim_r.neg  <= s2_nim_r[32];
      s3_fim_r.zero <= s2_d_r == 32'd0;
      s3_fim_r.ovf  <= 1'b0;
      s3_side_r     <= s3_side_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      vp_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r       <= in_tvalid;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      vp_r         <= {vp_r[LANE_DEPTH-2:0], s3_v_r};
      out_tvalid_r <= vp_r[LANE_DEPTH-1];
    end
  end

  // long lanes
  cau_divider u_div_re (
    .clk     (clk),
    .en      (adv),
    .num_i   (s3_nre_r),
    .den_i   (s3_d_r),
    .flags_i (s3_fre_r),
    .quo_o   (q_re),
    .flags_o (f_re)
  );

  cau_divider u_div_im (
    .clk     (clk),
    .en      (adv),
    .num_i   (s3_nim_r),
    .den_i   (s3_d_r),
    .flags_i (s3_fim_r),
    .quo_o   (q_im),
    .flags_o (f_im)
  );

  cau_sqrt u_sqrt (
    .clk        (clk),
    .en         (adv),
    .radicand_i (s3_mag_r),
    .root_o     (root)
  );

  cau_delay #(
    .W     ($bits(side_t)),
    .DEPTH (LANE_DEPTH)
  ) u_side (
    .clk  (clk),
    .en   (adv),
    .din  (s3_side_r),
    .dout (side_d)
  );

  // result select
  always_comb begin
    res_re_nxt = side_d.re;
    res_im_nxt = side_d.im;
    case (side_d.op)
      OP_DIV: begin
        res_re_nxt = div_sat(q_re, f_re);
        res_im_nxt = div_sat(q_im, f_im);
      end
      OP_MAG: begin
        res_re_nxt = root_sat(root);
        res_im_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_re_r    <= res_re_nxt;
      out_im_r    <= res_im_nxt;
      out_truth_r <= side_d.truth;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_truth_r, out_im_r, out_re_r};

endmodule

// ----- rtl/cau_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on complex_arith_unit_assert.svh.
`include "complex_arith_unit_assert.svh"

module cau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  `CAU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result word changed")
  `CAU_ASSERT(a_ready_free, !out_tvalid |-> in_tready, "input stalled with empty output")
  `CAU_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[39:33] == 7'd0, "nonzero tdata padding")
  `CAU_ASSERT(a_truth_zero, out_tvalid && out_tdata[32] |-> out_tdata[31:0] == 32'd0, "truth set with nonzero value")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for complex_arith_unit: directed and random words,
// predicted results checked in order. Depends on cau_pkg and the RTL.
module testbench;
  import cau_pkg::*;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               truth;
  } cres_t;

  class cau_scoreboard;
    cres_t pending[$];
    int    mismatches;

    function automatic longint isqrt(longint n);
      longint r;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n) r = r + (64'sd1 << b);
      end
      return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void note_input(op_t op, logic signed [15:0] ar, logic signed [15:0] ai,
                             logic signed [15:0] br, logic signed [15:0] bi);
      longint xr, xi, yr, yi, rr, ri, d, sc;
      cres_t e;
      xr = ar; xi = ai; yr = br; yi = bi;
      sc = 64'sd1 << CAU_FRAC_BITS;
      rr = 0; ri = 0; e.truth = 1'b0;
      case (op)
        OP_ADD: begin rr = xr + yr; ri = xi + yi; end
        OP_SUB: begin rr = xr - yr; ri = xi - yi; end
        OP_MUL: begin
          rr = (xr * yr - xi * yi) / sc;
          ri = (xr * yi + xi * yr) / sc;
        end
        OP_DIV: begin
          d = yr * yr + yi * yi;
          if (d != 0) begin
            rr = ((xr * yr + xi * yi) * sc) / d;
            ri = ((xi * yr - xr * yi) * sc) / d;
          end
        end
        OP_MAG: rr = isqrt(xr * xr + xi * xi);
        OP_CONJ: begin rr = xr; ri = -xi; end
        OP_EQ: e.truth = (xr == yr && xi == yi);
        default: e.truth = !(xr == yr && xi == yi);
      endcase
      e.re = clamp16(rr);
      e.im = clamp16(ri);
      pending.push_back(e);
    endfunction

    function void check_result(logic [39:0] d);
      cres_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.re || d[31:16] !== e.im || d[32] !== e.truth) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp re=%0d im=%0d t=%0b got re=%0d im=%0d t=%0b",
                   e.re, e.im, e.truth, $signed(d[15:0]), $signed(d[31:16]), d[32]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // op[2:0] a_re[18:3] a_im[34:19] b_re[50:35] b_im[66:51]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // res_re[15:0] res_im[31:16] truth[32]

  cau_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  complex_arith_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(op_t'(in_tdata[2:0]), in_tdata[18:3], in_tdata[34:19],
                    in_tdata[50:35], in_tdata[66:51]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] pick_val();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(op_t op, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, bi, br, ai, ar, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    logic [15:0] ar, ai, br, bi;
    for (int k = 0; k < n; k++) begin
      ar = pick_val(); ai = pick_val();
      if ($urandom_range(3) == 0) begin
        br = ar; bi = ai;
      end else begin
        br = pick_val(); bi = pick_val();
      end
      if ($urandom_range(9) == 0) begin
        br = 16'h0; bi = 16'h0;
      end
      send_word(op_t'($urandom_range(7)), ar, ai, br, bi);
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 87;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int o = 0; o < 8; o++) begin
      send_word(op_t'(o), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(op_t'(o), 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    end
    send_word(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
    send_word(OP_DIV, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0001);
    send_word(OP_MAG, 16'h0300, 16'h0400, 16'h1234, 16'h5678);
    send_word(OP_CONJ, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001);
    send_word(OP_EQ, 16'h0001, 16'h0002, 16'h0001, 16'h0002);
    send_word(OP_NE, 16'h0001, 16'h0002, 16'h0001, 16'h0003);
    send_word(OP_MUL, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001);
    in_tvalid <= 1'b0;

    send_random(550);
    send_idle_pct = 87;
    recv_idle_pct = 12;
    send_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles <= 200;
    send_random(730);
    drain();
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
